// ===== design/spr_pkg.sv =====
// ----------------------------------------------------------------------------
// spr_pkg
// Shared widths, constants and helpers for the spectral-to-RGB converter.
// ----------------------------------------------------------------------------
package spr_pkg;

    localparam int BAND_W   = 4;
    localparam int SAMPLE_W = 16;
    localparam int GAIN_W   = 24;
    localparam int WGT_W    = 18;
    localparam int ACC_W    = 44;
    localparam int OUT_W    = 16;

    // sample * gain, split in halves for the weight multiply
    localparam int SG_W     = SAMPLE_W + GAIN_W;
    localparam int SG_HALF  = SG_W / 2;
    localparam int PROD_W   = SG_HALF + WGT_W;
    localparam int TERM_W   = PROD_W;

    // matrix datapath
    localparam int COEF_W     = 16;
    localparam int MTX_HALF   = ACC_W / 2;
    localparam int MTX_OP_W   = MTX_HALF + 1;
    localparam int MPROD_W    = MTX_OP_W + COEF_W;
    localparam int MSUM_W     = MPROD_W + 2;
    localparam int MFULL_W    = 64;
    localparam int FRAC_SHIFT = 28;

    localparam int CFG_ADDR_W = 3;
    localparam int CFG_DATA_W = 32;

    localparam logic [ACC_W-1:0] ACC_MAX = {ACC_W{1'b1}};
    localparam logic [OUT_W-1:0] OUT_MAX = 16'd65280;
    localparam logic [GAIN_W-1:0] GAIN_RESET = 24'd65536;

    localparam logic KIND_LOAD   = 1'b0;
    localparam logic KIND_SAMPLE = 1'b1;

    localparam logic [0:0] REG_GAIN = 1'b0;

    // XYZ to linear RGB, signed Q4.12, row = channel, col = X/Y/Z
    function automatic logic signed [COEF_W-1:0] mtx_coef(input logic [1:0] row,
                                                           input logic [1:0] col);
        logic signed [COEF_W-1:0] c;
        case ({row, col})
            4'b0000: c = 16'sd14362;
            4'b0001: c = -16'sd7127;
            4'b0010: c = -16'sd2229;
            4'b0100: c = -16'sd4379;
            4'b0101: c = 16'sd8101;
            4'b0110: c = -16'sd144;
            4'b1000: c = 16'sd231;
            4'b1001: c = -16'sd807;
            4'b1010: c = 16'sd4305;
            default: c = '0;
        endcase
        return c;
    endfunction

    function automatic logic [ACC_W-1:0] sat_add(input logic [ACC_W-1:0] a,
                                                 input logic [TERM_W-1:0] t);
        logic [ACC_W:0] s;
        s = (ACC_W+1)'(a) + (ACC_W+1)'(t);
        return s[ACC_W] ? ACC_MAX : s[ACC_W-1:0];
    endfunction

endpackage

// ===== design/spr_ram.sv =====
// ----------------------------------------------------------------------------
// spr_ram
// Generic single-write, single-read RAM with registered read data.
// ----------------------------------------------------------------------------
module spr_ram #(
    parameter int WIDTH  = 8,
    parameter int DEPTH  = 16,
    parameter int ADDR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic              clk,
    input  logic              we,
    input  logic [ADDR_W-1:0] waddr,
    input  logic [WIDTH-1:0]  wdata,
    input  logic              re,
    input  logic [ADDR_W-1:0] raddr,
    output logic [WIDTH-1:0]  rdata
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        if (re)
        begin
            rdata <= mem[raddr];
        end
    end

endmodule

// ===== design/spr_matrix.sv =====
// ----------------------------------------------------------------------------
// spr_matrix
// Sequential XYZ-to-RGB matrix: one coefficient per step on split accumulator
// halves, then clamp of each channel to 0..255 in Q8.8.
// ----------------------------------------------------------------------------
module spr_matrix
    import spr_pkg::*;
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             start,
    input  logic [ACC_W-1:0] acc_x,
    input  logic [ACC_W-1:0] acc_y,
    input  logic [ACC_W-1:0] acc_z,
    output logic             done,
    output logic [OUT_W-1:0] red,
    output logic [OUT_W-1:0] green,
    output logic [OUT_W-1:0] blue
);

    typedef enum logic [3:0] {
        M_IDLE = 4'b0001,
        M_MUL  = 4'b0010,
        M_ADD  = 4'b0100,
        M_OUT  = 4'b1000
    } mstate_t;

    localparam int SHIFT_W = MFULL_W - 1 - FRAC_SHIFT;

    mstate_t state_reg, state_next;
    logic [1:0] row_reg, row_next;
    logic [1:0] col_reg, col_next;
    logic done_reg, done_next;

    logic signed [MPROD_W-1:0] prod_hi_reg, prod_hi_next;
    logic signed [MPROD_W-1:0] prod_lo_reg, prod_lo_next;
    logic signed [MSUM_W-1:0]  sum_hi_reg, sum_hi_next;
    logic signed [MSUM_W-1:0]  sum_lo_reg, sum_lo_next;
    logic [OUT_W-1:0] red_reg, red_next;
    logic [OUT_W-1:0] green_reg, green_next;
    logic [OUT_W-1:0] blue_reg, blue_next;

    logic [ACC_W-1:0]          acc_sel;
    logic signed [MTX_OP_W-1:0] hi_s;
    logic signed [MTX_OP_W-1:0] lo_s;
    logic signed [COEF_W-1:0]  coef;
    logic signed [MFULL_W-1:0] full_sum;
    logic [SHIFT_W-1:0]        shifted;
    logic [OUT_W-1:0]          chan_val;

    always_comb
    begin
        if (col_reg == 2'd0)
        begin
            acc_sel = acc_x;
        end
        else if (col_reg == 2'd1)
        begin
            acc_sel = acc_y;
        end
        else
        begin
            acc_sel = acc_z;
        end
        hi_s = signed'({1'b0, acc_sel[ACC_W-1:MTX_HALF]});
        lo_s = signed'({1'b0, acc_sel[MTX_HALF-1:0]});
        coef = mtx_coef(row_reg, col_reg);

        full_sum = (MFULL_W'(sum_hi_reg) <<< MTX_HALF) + MFULL_W'(sum_lo_reg);
        shifted  = full_sum[MFULL_W-2:FRAC_SHIFT];
        if (full_sum[MFULL_W-1] || (full_sum == '0))
        begin
            chan_val = '0;
        end
        else if (shifted > SHIFT_W'(OUT_MAX))
        begin
            chan_val = OUT_MAX;
        end
        else
        begin
            chan_val = shifted[OUT_W-1:0];
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        row_next     = row_reg;
        col_next     = col_reg;
        done_next    = 1'b0;
        prod_hi_next = prod_hi_reg;
        prod_lo_next = prod_lo_reg;
        sum_hi_next  = sum_hi_reg;
        sum_lo_next  = sum_lo_reg;
        red_next     = red_reg;
        green_next   = green_reg;
        blue_next    = blue_reg;

        case (state_reg)
            M_IDLE:
            begin
                if (start)
                begin
                    row_next    = '0;
                    col_next    = '0;
                    sum_hi_next = '0;
                    sum_lo_next = '0;
                    state_next  = M_MUL;
                end
            end
            M_MUL:
            begin
                prod_hi_next = MPROD_W'(hi_s) * MPROD_W'(coef);
                prod_lo_next = MPROD_W'(lo_s) * MPROD_W'(coef);
                state_next   = M_ADD;
            end
            M_ADD:
            begin
                sum_hi_next = sum_hi_reg + MSUM_W'(prod_hi_reg);
                sum_lo_next = sum_lo_reg + MSUM_W'(prod_lo_reg);
                if (col_reg == 2'd2)
                begin
                    state_next = M_OUT;
                end
                else
                begin
                    col_next   = col_reg + 2'd1;
                    state_next = M_MUL;
                end
            end
            M_OUT:
            begin
                if (row_reg == 2'd0)
                begin
                    red_next = chan_val;
                end
                else if (row_reg == 2'd1)
                begin
                    green_next = chan_val;
                end
                else
                begin
                    blue_next = chan_val;
                end
                sum_hi_next = '0;
                sum_lo_next = '0;
                col_next    = '0;
                if (row_reg == 2'd2)
                begin
                    done_next  = 1'b1;
                    state_next = M_IDLE;
                end
                else
                begin
                    row_next   = row_reg + 2'd1;
                    state_next = M_MUL;
                end
            end
            default:
            begin
                state_next = M_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= M_IDLE;
            row_reg   <= '0;
            col_reg   <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            row_reg   <= row_next;
            col_reg   <= col_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        prod_hi_reg <= prod_hi_next;
        prod_lo_reg <= prod_lo_next;
        sum_hi_reg  <= sum_hi_next;
        sum_lo_reg  <= sum_lo_next;
        red_reg     <= red_next;
        green_reg   <= green_next;
        blue_reg    <= blue_next;
    end

    assign done  = done_reg;
    assign red   = red_reg;
    assign green = green_reg;
    assign blue  = blue_reg;

endmodule

// ===== design/spectral_to_rgb_converter.sv =====
// ----------------------------------------------------------------------------
// spectral_to_rgb_converter
// Accumulates gain-scaled, weighted spectral samples into X, Y, Z and turns
// them into clamped linear RGB on the last sample of a pixel.
//
//   channel  | signals                                   | dir
//   ---------+-------------------------------------------+-----
//   input    | in_valid/in_stall, kind band weight_x/y/z  | in
//            | sample last                                |
//   output   | out_valid/out_stall, red green blue        | out
//   config   | APB: psel penable pwrite paddr pwdata ...  | in
//
// A weight load is written straight from idle; a sample passes through weight
// RAM read, split multiply, term add and saturating accumulate. A last sample
// also waits for the shared two-multiplier matrix unit stepping through 9 terms.
// Reset clears the accumulators; the weight RAM is not cleared.
// A result waits in the output register while the next pixel accumulates.
// ----------------------------------------------------------------------------
module spectral_to_rgb_converter
    import spr_pkg::*;
#(
    parameter int NUM_BANDS = 16
) (
    input  logic                  clk,
    input  logic                  rst_n,

    input  logic                  in_valid,
    output logic                  in_stall,
    input  logic                  kind,
    input  logic [BAND_W-1:0]     band,
    input  logic [WGT_W-1:0]      weight_x,
    input  logic [WGT_W-1:0]      weight_y,
    input  logic [WGT_W-1:0]      weight_z,
    input  logic [SAMPLE_W-1:0]   sample,
    input  logic                  last,

    output logic                  out_valid,
    input  logic                  out_stall,
    output logic [OUT_W-1:0]      red,
    output logic [OUT_W-1:0]      green,
    output logic [OUT_W-1:0]      blue,

    input  logic                  psel,
    input  logic                  penable,
    input  logic                  pwrite,
    input  logic [CFG_ADDR_W-1:0] paddr,
    input  logic [CFG_DATA_W-1:0] pwdata,
    output logic [CFG_DATA_W-1:0] prdata,
    output logic                  pready
);

    localparam int ADDR_W     = (NUM_BANDS > 1) ? $clog2(NUM_BANDS) : 1;
    localparam int BAND_EXT_W = (ADDR_W > BAND_W) ? ADDR_W : BAND_W;
    localparam int ENTRY_W    = 3 * WGT_W;

    typedef enum logic [5:0] {
        ST_IDLE = 6'b000001,
        ST_MUL  = 6'b000010,
        ST_TERM = 6'b000100,
        ST_ACC  = 6'b001000,
        ST_MTX  = 6'b010000,
        ST_EMIT = 6'b100000
    } state_t;

    state_t state_reg, state_next;
    logic band_ok_reg, band_ok_next;
    logic last_reg, last_next;
    logic out_valid_reg, out_valid_next;
    logic [GAIN_W-1:0] gain_reg, gain_next;
    logic [ACC_W-1:0] acc_x_reg, acc_x_next;
    logic [ACC_W-1:0] acc_y_reg, acc_y_next;
    logic [ACC_W-1:0] acc_z_reg, acc_z_next;

    logic [SG_W-1:0]   sg_reg, sg_next;
    logic [PROD_W-1:0] pxh_reg, pxh_next, pxl_reg, pxl_next;
    logic [PROD_W-1:0] pyh_reg, pyh_next, pyl_reg, pyl_next;
    logic [PROD_W-1:0] pzh_reg, pzh_next, pzl_reg, pzl_next;
    logic [TERM_W-1:0] term_x_reg, term_x_next;
    logic [TERM_W-1:0] term_y_reg, term_y_next;
    logic [TERM_W-1:0] term_z_reg, term_z_next;
    logic [OUT_W-1:0]  red_reg, red_next;
    logic [OUT_W-1:0]  green_reg, green_next;
    logic [OUT_W-1:0]  blue_reg, blue_next;

    logic                  band_ok;
    logic [BAND_EXT_W-1:0] band_ext;
    logic [ADDR_W-1:0]     band_addr;
    logic                  ram_we;
    logic                  ram_re;
    logic [ENTRY_W-1:0]    ram_wdata;
    logic [ENTRY_W-1:0]    ram_rdata;
    logic [WGT_W-1:0]      w_x, w_y, w_z;
    logic [SG_HALF-1:0]    sg_hi, sg_lo;
    logic                  cfg_write;
    logic                  mtx_start;
    logic                  mtx_done;
    logic [OUT_W-1:0]      mtx_red, mtx_green, mtx_blue;
    logic                  emit;

    assign band_ext  = BAND_EXT_W'(band);
    assign band_addr = band_ext[ADDR_W-1:0];
    assign band_ok   = (int'(band) < NUM_BANDS);
    assign ram_wdata = {weight_z, weight_y, weight_x};
    assign w_x       = ram_rdata[WGT_W-1:0];
    assign w_y       = ram_rdata[2*WGT_W-1:WGT_W];
    assign w_z       = ram_rdata[3*WGT_W-1:2*WGT_W];
    assign sg_hi     = sg_reg[SG_W-1:SG_HALF];
    assign sg_lo     = sg_reg[SG_HALF-1:0];

    spr_ram #(
        .WIDTH (ENTRY_W),
        .DEPTH (NUM_BANDS)
    ) u_weight_ram (
        .clk   (clk),
        .we    (ram_we),
        .waddr (band_addr),
        .wdata (ram_wdata),
        .re    (ram_re),
        .raddr (band_addr),
        .rdata (ram_rdata)
    );

    spr_matrix u_matrix (
        .clk   (clk),
        .rst_n (rst_n),
        .start (mtx_start),
        .acc_x (acc_x_reg),
        .acc_y (acc_y_reg),
        .acc_z (acc_z_reg),
        .done  (mtx_done),
        .red   (mtx_red),
        .green (mtx_green),
        .blue  (mtx_blue)
    );

    // configuration
    assign cfg_write = psel && penable && pwrite && pready;
    assign gain_next = (cfg_write && (paddr[2:2] == REG_GAIN)) ?
                       pwdata[GAIN_W-1:0] : gain_reg;
    assign prdata    = (paddr[2:2] == REG_GAIN) ? CFG_DATA_W'(gain_reg) : '0;
    assign pready    = 1'b1;

    always_comb
    begin
        state_next   = state_reg;
        band_ok_next = band_ok_reg;
        last_next    = last_reg;
        acc_x_next   = acc_x_reg;
        acc_y_next   = acc_y_reg;
        acc_z_next   = acc_z_reg;
        sg_next      = sg_reg;
        pxh_next     = pxh_reg;
        pxl_next     = pxl_reg;
        pyh_next     = pyh_reg;
        pyl_next     = pyl_reg;
        pzh_next     = pzh_reg;
        pzl_next     = pzl_reg;
        term_x_next  = term_x_reg;
        term_y_next  = term_y_reg;
        term_z_next  = term_z_reg;
        red_next     = red_reg;
        green_next   = green_reg;
        blue_next    = blue_reg;
        ram_we       = 1'b0;
        ram_re       = 1'b0;
        mtx_start    = 1'b0;
        emit         = 1'b0;

        case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    if (kind == KIND_SAMPLE)
                    begin
                        ram_re       = band_ok;
                        sg_next      = SG_W'(sample) * SG_W'(gain_reg);
                        band_ok_next = band_ok;
                        last_next    = last;
                        state_next   = ST_MUL;
                    end
                    else
                    begin
                        ram_we = band_ok;
                    end
                end
            end
            ST_MUL:
            begin
                pxh_next   = PROD_W'(sg_hi) * PROD_W'(w_x);
                pxl_next   = PROD_W'(sg_lo) * PROD_W'(w_x);
                pyh_next   = PROD_W'(sg_hi) * PROD_W'(w_y);
                pyl_next   = PROD_W'(sg_lo) * PROD_W'(w_y);
                pzh_next   = PROD_W'(sg_hi) * PROD_W'(w_z);
                pzl_next   = PROD_W'(sg_lo) * PROD_W'(w_z);
                state_next = ST_TERM;
            end
            ST_TERM:
            begin
                if (band_ok_reg)
                begin
                    term_x_next = pxh_reg + PROD_W'(pxl_reg[PROD_W-1:SG_HALF]);
                    term_y_next = pyh_reg + PROD_W'(pyl_reg[PROD_W-1:SG_HALF]);
                    term_z_next = pzh_reg + PROD_W'(pzl_reg[PROD_W-1:SG_HALF]);
                end
                else
                begin
                    term_x_next = '0;
                    term_y_next = '0;
                    term_z_next = '0;
                end
                state_next = ST_ACC;
            end
            ST_ACC:
            begin
                acc_x_next = sat_add(acc_x_reg, term_x_reg);
                acc_y_next = sat_add(acc_y_reg, term_y_reg);
                acc_z_next = sat_add(acc_z_reg, term_z_reg);
                if (last_reg)
                begin
                    mtx_start  = 1'b1;
                    state_next = ST_MTX;
                end
                else
                begin
                    state_next = ST_IDLE;
                end
            end
            ST_MTX:
            begin
                if (mtx_done)
                begin
                    state_next = ST_EMIT;
                end
            end
            ST_EMIT:
            begin
                if (!out_valid_reg || !out_stall)
                begin
                    emit       = 1'b1;
                    red_next   = mtx_red;
                    green_next = mtx_green;
                    blue_next  = mtx_blue;
                    acc_x_next = '0;
                    acc_y_next = '0;
                    acc_z_next = '0;
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase

        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && out_stall;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            band_ok_reg   <= 1'b0;
            last_reg      <= 1'b0;
            out_valid_reg <= 1'b0;
            gain_reg      <= GAIN_RESET;
            acc_x_reg     <= '0;
            acc_y_reg     <= '0;
            acc_z_reg     <= '0;
        end
        else
        begin
            state_reg     <= state_next;
            band_ok_reg   <= band_ok_next;
            last_reg      <= last_next;
            out_valid_reg <= out_valid_next;
            gain_reg      <= gain_next;
            acc_x_reg     <= acc_x_next;
            acc_y_reg     <= acc_y_next;
            acc_z_reg     <= acc_z_next;
        end
    end

    always_ff @(posedge clk)
    begin
        sg_reg     <= sg_next;
        pxh_reg    <= pxh_next;
        pxl_reg    <= pxl_next;
        pyh_reg    <= pyh_next;
        pyl_reg    <= pyl_next;
        pzh_reg    <= pzh_next;
        pzl_reg    <= pzl_next;
        term_x_reg <= term_x_next;
        term_y_reg <= term_y_next;
        term_z_reg <= term_z_next;
        red_reg    <= red_next;
        green_reg  <= green_next;
        blue_reg   <= blue_next;
    end

    assign in_stall  = (state_reg != ST_IDLE);
    assign out_valid = out_valid_reg;
    assign red       = red_reg;
    assign green     = green_reg;
    assign blue      = blue_reg;

    // a new result appears only out of the emit state
    a_rise_from_emit: assert property (@(posedge clk) disable iff (!rst_n)
        $rose(out_valid_reg) |-> $past(state_reg == ST_EMIT))
        else $error("result raised outside emit");

    // matrix completes only while the controller waits for it
    a_done_in_mtx: assert property (@(posedge clk) disable iff (!rst_n)
        mtx_done |-> (state_reg == ST_MTX))
        else $error("matrix done while not waiting");

    // accumulators are clear after a result is handed over
    a_acc_cleared: assert property (@(posedge clk) disable iff (!rst_n)
        emit |=> (acc_x_reg == '0) && (acc_y_reg == '0) && (acc_z_reg == '0))
        else $error("accumulators not cleared after result");

endmodule

// ===== sim/spectral_to_rgb_converter_test.sv =====
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// spectral_to_rgb_converter_test
// Drives weight loads and spectral samples into the converter under random
// idling on both channels and compares every RGB pixel with a cycle-free
// predictor of the XYZ accumulation, matrix and clamp. A short directed table
// runs first, then well-formed random pixels under several gain settings,
// including the gain extremes, saturated accumulators and a held-off output.
// ----------------------------------------------------------------------------
module spectral_to_rgb_converter_test;
    import spr_pkg::*;

    localparam int NUM_BANDS     = 16;
    localparam int TERM_SHIFT    = 20;
    localparam int SETTLE_CYCLES = 40;
    localparam int HOLD_CYCLES   = 300;
    localparam longint TIMEOUT_NS = 5_000_000;

    localparam logic [CFG_ADDR_W-1:0] ADDR_GAIN  = CFG_ADDR_W'(REG_GAIN) << 2;
    localparam logic [CFG_ADDR_W-1:0] ADDR_SPARE = 3'd4;

    localparam logic [WGT_W-1:0]    W_MAX = {WGT_W{1'b1}};
    localparam logic [SAMPLE_W-1:0] S_MAX = {SAMPLE_W{1'b1}};

    typedef struct packed {
        logic                kind;
        logic [BAND_W-1:0]   band;
        logic [WGT_W-1:0]    wx;
        logic [WGT_W-1:0]    wy;
        logic [WGT_W-1:0]    wz;
        logic [SAMPLE_W-1:0] sample;
        logic                last;
    } item_t;

    typedef struct packed {
        logic [OUT_W-1:0] red;
        logic [OUT_W-1:0] green;
        logic [OUT_W-1:0] blue;
    } rgb_t;

    typedef struct packed {
        item_t it;
        logic  known;
        rgb_t  want;
    } row_t;

    localparam rgb_t ZERO_RGB = '0;

    logic                  clk;
    logic                  rst_n;
    logic                  in_valid;
    logic                  in_stall;
    logic                  kind;
    logic [BAND_W-1:0]     band;
    logic [WGT_W-1:0]      weight_x;
    logic [WGT_W-1:0]      weight_y;
    logic [WGT_W-1:0]      weight_z;
    logic [SAMPLE_W-1:0]   sample;
    logic                  last;
    logic                  out_valid;
    logic                  out_stall;
    logic [OUT_W-1:0]      red;
    logic [OUT_W-1:0]      green;
    logic [OUT_W-1:0]      blue;
    logic                  psel;
    logic                  penable;
    logic                  pwrite;
    logic [CFG_ADDR_W-1:0] paddr;
    logic [CFG_DATA_W-1:0] pwdata;
    logic [CFG_DATA_W-1:0] prdata;
    logic                  pready;

    // predictor state
    logic [WGT_W-1:0]  wgt_x [NUM_BANDS];
    logic [WGT_W-1:0]  wgt_y [NUM_BANDS];
    logic [WGT_W-1:0]  wgt_z [NUM_BANDS];
    logic [NUM_BANDS-1:0] band_ready;
    logic [ACC_W-1:0]  sum_x;
    logic [ACC_W-1:0]  sum_y;
    logic [ACC_W-1:0]  sum_z;
    logic [GAIN_W-1:0] gain_reg;

    rgb_t expected_rgb [$];
    row_t dir_rows [$];

    int errors;
    int transfers_in;
    int pixels_checked;
    int gains_set;
    int rx_hold_req;
    bit tx_calm;
    bit rx_calm;
    int tx_run;
    int rx_run;

    spectral_to_rgb_converter #(.NUM_BANDS(NUM_BANDS)) dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .band      (band),
        .weight_x  (weight_x),
        .weight_y  (weight_y),
        .weight_z  (weight_z),
        .sample    (sample),
        .last      (last),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .red       (red),
        .green     (green),
        .blue      (blue),
        .psel      (psel),
        .penable   (penable),
        .pwrite    (pwrite),
        .paddr     (paddr),
        .pwdata    (pwdata),
        .prdata    (prdata),
        .pready    (pready)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    initial
    begin
        #(TIMEOUT_NS);
        $display("Timeout at %0t ns", $time);
        $display("Simulation FAILED");
        $finish;
    end

    function automatic item_t mk(input logic k, input logic [BAND_W-1:0] b,
                                 input logic [WGT_W-1:0] wx, input logic [WGT_W-1:0] wy,
                                 input logic [WGT_W-1:0] wz,
                                 input logic [SAMPLE_W-1:0] s, input logic l);
        item_t it;
        it.kind   = k;
        it.band   = b;
        it.wx     = wx;
        it.wy     = wy;
        it.wz     = wz;
        it.sample = s;
        it.last   = l;
        return it;
    endfunction

    function automatic int draw_gap(inout bit calm, inout int run_left);
        if (run_left == 0)
        begin
            calm     = ($urandom_range(0, 2) == 0);
            run_left = $urandom_range(20, 60);
        end
        run_left--;
        if (calm)
            return 0;
        return ($urandom_range(0, 1) == 0) ? 0 : $urandom_range(1, 18);
    endfunction

    function automatic logic [WGT_W-1:0] draw_weight();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return W_MAX;
            default: return WGT_W'($urandom);
        endcase
    endfunction

    function automatic logic [SAMPLE_W-1:0] draw_level();
        case ($urandom_range(0, 7))
            0:       return '0;
            1:       return S_MAX;
            default: return SAMPLE_W'($urandom);
        endcase
    endfunction

    function automatic logic [ACC_W-1:0] acc_sat(input logic [ACC_W-1:0] acc,
                                                 input logic [63:0] term);
        logic [ACC_W:0] s;
        s = {1'b0, acc} + term[ACC_W:0];
        return s[ACC_W] ? {ACC_W{1'b1}} : s[ACC_W-1:0];
    endfunction

    function automatic logic [OUT_W-1:0] clamp_q88(input longint s);
        longint v;
        if (s <= 0)
            return '0;
        v = s >>> FRAC_SHIFT;
        return (v > longint'(OUT_MAX)) ? OUT_MAX : OUT_W'(v);
    endfunction

    function automatic bit predict_pixel(input item_t it, output rgb_t px);
        logic [63:0] sg;
        longint x;
        longint y;
        longint z;
        px = '0;
        if (it.kind == KIND_LOAD)
        begin
            wgt_x[it.band] = it.wx;
            wgt_y[it.band] = it.wy;
            wgt_z[it.band] = it.wz;
            band_ready[it.band] = 1'b1;
            return 1'b0;
        end
        sg    = 64'(it.sample) * 64'(gain_reg);
        sum_x = acc_sat(sum_x, (sg * 64'(wgt_x[it.band])) >> TERM_SHIFT);
        sum_y = acc_sat(sum_y, (sg * 64'(wgt_y[it.band])) >> TERM_SHIFT);
        sum_z = acc_sat(sum_z, (sg * 64'(wgt_z[it.band])) >> TERM_SHIFT);
        if (!it.last)
            return 1'b0;
        x = longint'(sum_x);
        y = longint'(sum_y);
        z = longint'(sum_z);
        px.red   = clamp_q88(14362 * x - 7127 * y - 2229 * z);
        px.green = clamp_q88(-4379 * x + 8101 * y - 144 * z);
        px.blue  = clamp_q88(231 * x - 807 * y + 4305 * z);
        sum_x = '0;
        sum_y = '0;
        sum_z = '0;
        return 1'b1;
    endfunction

    function automatic void check_field(input string name, input logic [OUT_W-1:0] want,
                                        input logic [OUT_W-1:0] got);
        if (got !== want)
        begin
            $display("%0t ns: %s mismatch, expected %0d, got %0d", $time, name, want, got);
            errors++;
        end
    endfunction

    function automatic logic [BAND_W-1:0] pick_loaded_band();
        logic [BAND_W-1:0] b;
        do
            b = BAND_W'($urandom_range(0, NUM_BANDS - 1));
        while (!band_ready[b]);
        return b;
    endfunction

    task automatic push_item(input item_t it, input logic known, input rgb_t want);
        int   n;
        rgb_t px;
        n = draw_gap(tx_calm, tx_run);
        if (n > 0)
        begin
            in_valid <= 1'b0;
            repeat (n) @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= it.kind;
        band     <= it.band;
        weight_x <= it.wx;
        weight_y <= it.wy;
        weight_z <= it.wz;
        sample   <= it.sample;
        last     <= it.last;
        @(posedge clk);
        while (in_stall)
            @(posedge clk);
        transfers_in++;
        if (predict_pixel(it, px))
            expected_rgb.push_back(known ? want : px);
    endtask

    task automatic settle();
        in_valid <= 1'b0;
        while (expected_rgb.size() != 0)
            @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic cfg_write(input logic [CFG_ADDR_W-1:0] addr,
                             input logic [CFG_DATA_W-1:0] data);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= addr;
        pwdata  <= data;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (addr == ADDR_GAIN)
        begin
            gain_reg = data[GAIN_W-1:0];
            gains_set++;
        end
        @(posedge clk);
    endtask

    task automatic cfg_read_check(input logic [CFG_ADDR_W-1:0] addr,
                                  input logic [CFG_DATA_W-1:0] want);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        paddr   <= addr;
        @(posedge clk);
        penable <= 1'b1;
        @(posedge clk);
        while (!pready)
            @(posedge clk);
        if (prdata !== want)
        begin
            $display("%0t ns: register read mismatch, expected %0d, got %0d",
                     $time, want, prdata);
            errors++;
        end
        psel    <= 1'b0;
        penable <= 1'b0;
    endtask

    task automatic set_gain(input logic [CFG_DATA_W-1:0] data);
        settle();
        cfg_write(ADDR_GAIN, data);
        cfg_read_check(ADDR_GAIN, CFG_DATA_W'(gain_reg));
    endtask

    // one band at full weights, long run of bright samples: all sums saturate
    task automatic saturating_pixel();
        logic [BAND_W-1:0] b;
        int k;
        b = BAND_W'($urandom_range(0, NUM_BANDS - 1));
        push_item(mk(KIND_LOAD, b, W_MAX, W_MAX, W_MAX, draw_level(), 1'b0), 1'b0, ZERO_RGB);
        for (k = 0; k < 100; k++)
            push_item(mk(KIND_SAMPLE, b, draw_weight(), draw_weight(), draw_weight(),
                         SAMPLE_W'($urandom_range(16'hC000, 16'hFFFF)), k == 99),
                      1'b0, ZERO_RGB);
    endtask

    task automatic random_pixels(input int count);
        int len;
        int k;
        logic eop;
        while (count > 0)
        begin
            len = ($urandom_range(0, 9) == 0) ? $urandom_range(16, 40) : $urandom_range(1, 8);
            for (k = 0; k < len; k++)
            begin
                if ($urandom_range(0, 11) == 0)
                    push_item(mk(KIND_LOAD, BAND_W'($urandom_range(0, NUM_BANDS - 1)),
                                 draw_weight(), draw_weight(), draw_weight(), draw_level(),
                                 1'($urandom_range(0, 1))), 1'b0, ZERO_RGB);
                eop = (k == len - 1) || ($urandom_range(0, 24) == 0);
                push_item(mk(KIND_SAMPLE, pick_loaded_band(), draw_weight(), draw_weight(),
                             draw_weight(), draw_level(), eop), 1'b0, ZERO_RGB);
            end
            count -= len;
        end
    endtask

    initial
    begin : receiver
        int n;
        out_stall <= 1'b0;
        @(posedge rst_n);
        forever
        begin
            if (rx_hold_req > 0)
            begin
                n = rx_hold_req;
                rx_hold_req = 0;
            end
            else
                n = draw_gap(rx_calm, rx_run);
            if (n > 0)
            begin
                out_stall <= 1'b1;
                repeat (n) @(posedge clk);
                out_stall <= 1'b0;
            end
            @(posedge clk);
            while (!(out_valid && !out_stall))
                @(posedge clk);
        end
    end

    always @(posedge clk)
    begin
        rgb_t want;
        if (rst_n === 1'b1 && out_valid && !out_stall)
        begin
            if (expected_rgb.size() == 0)
            begin
                $display("%0t ns: unexpected pixel, expected none, got r=%0d g=%0d b=%0d",
                         $time, red, green, blue);
                errors++;
            end
            else
            begin
                want = expected_rgb.pop_front();
                check_field("red", want.red, red);
                check_field("green", want.green, green);
                check_field("blue", want.blue, blue);
                pixels_checked++;
            end
        end
    end

    initial
    begin : stimulus
        int p;
        rst_n    <= 1'b0;
        in_valid <= 1'b0;
        kind     <= KIND_LOAD;
        band     <= '0;
        weight_x <= '0;
        weight_y <= '0;
        weight_z <= '0;
        sample   <= '0;
        last     <= 1'b0;
        psel     <= 1'b0;
        penable  <= 1'b0;
        pwrite   <= 1'b0;
        paddr    <= '0;
        pwdata   <= '0;
        errors         = 0;
        transfers_in   = 0;
        pixels_checked = 0;
        gains_set      = 0;
        rx_hold_req    = 0;
        tx_run         = 0;
        rx_run         = 0;
        band_ready     = '0;
        sum_x          = '0;
        sum_y          = '0;
        sum_z          = '0;
        gain_reg       = GAIN_RESET;

        // directed table; zero pixels typed in, the rest predicted
        dir_rows.push_back({mk(KIND_LOAD, 4'd0, W_MAX, '0, '0, S_MAX, 1'b0), 1'b0, ZERO_RGB});
        dir_rows.push_back({mk(KIND_LOAD, 4'd1, '0, W_MAX, '0, '0, 1'b0), 1'b0, ZERO_RGB});
        dir_rows.push_back({mk(KIND_LOAD, 4'd2, '0, '0, W_MAX, '0, 1'b0), 1'b0, ZERO_RGB});
        dir_rows.push_back({mk(KIND_LOAD, 4'd15, '0, '0, '0, S_MAX, 1'b1), 1'b0, ZERO_RGB});
        dir_rows.push_back({mk(KIND_SAMPLE, 4'd15, W_MAX, W_MAX, W_MAX, S_MAX, 1'b1),
                            1'b1, ZERO_RGB});
        dir_rows.push_back({mk(KIND_SAMPLE, 4'd0, W_MAX, W_MAX, W_MAX, '0, 1'b1),
                            1'b1, ZERO_RGB});
        dir_rows.push_back({mk(KIND_SAMPLE, 4'd0, W_MAX, '0, W_MAX, S_MAX, 1'b0), 1'b0, ZERO_RGB});
        dir_rows.push_back({mk(KIND_SAMPLE, 4'd0, '0, '0, '0, S_MAX, 1'b1), 1'b0, ZERO_RGB});
        dir_rows.push_back({mk(KIND_SAMPLE, 4'd1, '0, '0, '0, S_MAX, 1'b1), 1'b0, ZERO_RGB});
        dir_rows.push_back({mk(KIND_SAMPLE, 4'd2, '0, '0, '0, S_MAX, 1'b1), 1'b0, ZERO_RGB});
        dir_rows.push_back({mk(KIND_LOAD, 4'd3, W_MAX, W_MAX, W_MAX, '0, 1'b0), 1'b0, ZERO_RGB});
        dir_rows.push_back({mk(KIND_SAMPLE, 4'd3, '0, '0, '0, S_MAX, 1'b1), 1'b0, ZERO_RGB});
        dir_rows.push_back({mk(KIND_LOAD, 4'd4, 18'h15555, 18'h2AAAA, 18'h15555, 16'h5555,
                               1'b0), 1'b0, ZERO_RGB});
        dir_rows.push_back({mk(KIND_SAMPLE, 4'd4, 18'h2AAAA, 18'h15555, 18'h2AAAA, 16'hAAAA,
                               1'b0), 1'b0, ZERO_RGB});
        dir_rows.push_back({mk(KIND_SAMPLE, 4'd4, '0, '0, '0, 16'h5555, 1'b1), 1'b0, ZERO_RGB});
        dir_rows.push_back({mk(KIND_SAMPLE, 4'd1, '0, '0, '0, 16'h0001, 1'b1), 1'b0, ZERO_RGB});
        dir_rows.push_back({mk(KIND_SAMPLE, 4'd0, '0, '0, '0, 16'h8000, 1'b0), 1'b0, ZERO_RGB});
        dir_rows.push_back({mk(KIND_SAMPLE, 4'd2, '0, '0, '0, 16'h1000, 1'b0), 1'b0, ZERO_RGB});
        dir_rows.push_back({mk(KIND_SAMPLE, 4'd1, '0, '0, '0, 16'h0800, 1'b1), 1'b0, ZERO_RGB});

        repeat (4) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        cfg_read_check(ADDR_GAIN, CFG_DATA_W'(GAIN_RESET));

        foreach (dir_rows[i])
            push_item(dir_rows[i].it, dir_rows[i].known, dir_rows[i].want);

        // write to an unmapped slot must leave the gain alone
        settle();
        cfg_write(ADDR_SPARE, $urandom);
        cfg_read_check(ADDR_GAIN, CFG_DATA_W'(gain_reg));

        for (p = 0; p < 5; p++)
        begin
            case (p)
                0:
                begin
                    set_gain(32'hFFFF_FFFF);
                    saturating_pixel();
                    random_pixels(150);
                end
                1:
                begin
                    set_gain('0);
                    random_pixels(120);
                end
                2:
                begin
                    set_gain($urandom);
                    random_pixels(150);
                end
                3:
                begin
                    set_gain(CFG_DATA_W'(GAIN_RESET));
                    rx_hold_req = HOLD_CYCLES;
                    random_pixels(160);
                end
                default:
                begin
                    set_gain(CFG_DATA_W'($urandom_range(1, 16'hFFFF)));
                    random_pixels(150);
                end
            endcase
        end

        settle();
        $display("Run covered %0d input transfers and %0d checked pixels under %0d gain writes,",
                 transfers_in, pixels_checked, gains_set);
        $display("including gain extremes, saturated sums and a long output hold-off.");
        if (errors == 0)
            $display("Simulation PASSED");
        else
            $display("Simulation FAILED");
        $finish;
    end

endmodule

// ===== sim.f =====
design/spr_pkg.sv
design/spr_ram.sv
design/spr_matrix.sv
design/spectral_to_rgb_converter.sv
sim/spectral_to_rgb_converter_test.sv
